// ===== hw/rtl/xalu_pkg.sv =====
// Shared types, flag positions and width helpers for the integer ALU with flags.
package xalu_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned WidthW = 2;
  localparam int unsigned FlagW  = 6;
  localparam int unsigned CntW   = 6;

  localparam int unsigned FL_CF = 0;
  localparam int unsigned FL_PF = 1;
  localparam int unsigned FL_AF = 2;
  localparam int unsigned FL_ZF = 3;
  localparam int unsigned FL_SF = 4;
  localparam int unsigned FL_OF = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 4'd0,
    CMD_INC  = 4'd1,
    CMD_SUB  = 4'd2,
    CMD_SBB  = 4'd3,
    CMD_CMP  = 4'd4,
    CMD_DEC  = 4'd5,
    CMD_AND  = 4'd6,
    CMD_OR   = 4'd7,
    CMD_XOR  = 4'd8,
    CMD_TEST = 4'd9,
    CMD_SHL  = 4'd10,
    CMD_SHR  = 4'd11,
    CMD_SAR  = 4'd12
  } cmd_e;

  typedef enum logic [WidthW-1:0] {
    WID_8  = 2'd0,
    WID_16 = 2'd1,
    WID_32 = 2'd2,
    WID_64 = 2'd3
  } width_e;

  function automatic logic [DataW-1:0] width_mask(input width_e wc);
    logic [DataW-1:0] m;
    case (wc)
      WID_8:   m = 64'h0000_0000_0000_00FF;
      WID_16:  m = 64'h0000_0000_0000_FFFF;
      WID_32:  m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] width_sign(input width_e wc);
    logic [DataW-1:0] s;
    case (wc)
      WID_8:   s = 64'h0000_0000_0000_0080;
      WID_16:  s = 64'h0000_0000_0000_8000;
      WID_32:  s = 64'h0000_0000_8000_0000;
      default: s = 64'h8000_0000_0000_0000;
    endcase
    return s;
  endfunction

  // bit just above the operand width of a 65-bit intermediate
  function automatic logic carry_at(input logic [DataW:0] v, input width_e wc);
    logic c;
    case (wc)
      WID_8:   c = v[8];
      WID_16:  c = v[16];
      WID_32:  c = v[32];
      default: c = v[64];
    endcase
    return c;
  endfunction

  function automatic logic [FlagW-1:0] status_flags(input logic [DataW-1:0] r,
                                                     input logic [DataW-1:0] s);
    logic [FlagW-1:0] f;
    f        = '0;
    f[FL_PF] = ~^r[7:0];
    f[FL_ZF] = (r == '0);
    f[FL_SF] = |(r & s);
    return f;
  endfunction

endpackage

// ===== hw/rtl/xalu_shift.sv =====
// Barrel shifter for SHL, SHR and SAR with carry-out and zero-count detect.
module xalu_shift (
  input  xalu_pkg::cmd_e                  op_i,
  input  xalu_pkg::width_e                wc_i,
  input  logic [xalu_pkg::DataW-1:0]      a_i,
  input  logic [xalu_pkg::CntW-1:0]       count_raw_i,
  input  logic [xalu_pkg::DataW-1:0]      mask_i,
  input  logic [xalu_pkg::DataW-1:0]      sign_i,
  output logic [xalu_pkg::DataW-1:0]      result_o,
  output logic                            cf_o,
  output logic                            cnt_zero_o
);
  import xalu_pkg::*;

  logic [CntW-1:0]         cnt;
  logic [DataW:0]          shl_t;
  logic [DataW:0]          shr_t;
  logic [DataW-1:0]        ext;
  logic signed [DataW:0]   sar_t;

  assign cnt        = (wc_i == WID_64) ? count_raw_i : {1'b0, count_raw_i[CntW-2:0]};
  assign cnt_zero_o = (cnt == '0);

  assign shl_t = {1'b0, a_i} << cnt;
  assign shr_t = {a_i, 1'b0} >> cnt;
  assign ext   = (|(a_i & sign_i)) ? (a_i | ~mask_i) : a_i;
  assign sar_t = $signed({ext, 1'b0}) >>> cnt;

  always_comb begin
    case (op_i)
      CMD_SHL: begin
        result_o = shl_t[DataW-1:0] & mask_i;
        cf_o     = carry_at(shl_t, wc_i);
      end
      CMD_SHR: begin
        result_o = shr_t[DataW:1];
        cf_o     = shr_t[0];
      end
      default: begin
        result_o = sar_t[DataW:1] & mask_i;
        cf_o     = sar_t[0];
      end
    endcase
  end

endmodule

// ===== hw/rtl/xalu_core.sv =====
// Combinational ALU datapath: adder, subtractor, logic ops, shifter and flag logic.
module xalu_core (
  input  logic [xalu_pkg::CmdW-1:0]   cmd_i,
  input  logic [xalu_pkg::WidthW-1:0] width_code_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_a_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_b_i,
  input  logic [xalu_pkg::FlagW-1:0]  flags_in_i,
  output logic [xalu_pkg::DataW-1:0]  result_o,
  output logic [xalu_pkg::FlagW-1:0]  flags_out_o,
  output logic                        write_back_o
);
  import xalu_pkg::*;

  cmd_e             op;
  width_e           wc;
  logic [DataW-1:0] mask;
  logic [DataW-1:0] sign;
  logic [DataW-1:0] a;
  logic [DataW-1:0] b;
  logic [DataW-1:0] b_eff;
  logic             cin;
  logic [DataW:0]   sum;
  logic [DataW:0]   diff;
  logic [DataW-1:0] add_r;
  logic [DataW-1:0] sub_r;
  logic [DataW-1:0] sh_r;
  logic             sh_cf;
  logic             sh_zero;
  logic [FlagW-1:0] f;

  assign op   = cmd_e'(cmd_i);
  assign wc   = width_e'(width_code_i);
  assign mask = width_mask(wc);
  assign sign = width_sign(wc);
  assign a    = operand_a_i & mask;
  assign b    = operand_b_i & mask;

  assign b_eff = (op == CMD_INC || op == CMD_DEC) ? {{(DataW-1){1'b0}}, 1'b1} : b;
  assign cin   = (op == CMD_SBB) & flags_in_i[FL_CF];
  assign sum   = {1'b0, a} + {1'b0, b_eff};
  assign diff  = {1'b0, a} - {1'b0, b_eff} - {{DataW{1'b0}}, cin};
  assign add_r = sum[DataW-1:0] & mask;
  assign sub_r = diff[DataW-1:0] & mask;

  xalu_shift u_shift (
    .op_i        (op),
    .wc_i        (wc),
    .a_i         (a),
    .count_raw_i (operand_b_i[CntW-1:0]),
    .mask_i      (mask),
    .sign_i      (sign),
    .result_o    (sh_r),
    .cf_o        (sh_cf),
    .cnt_zero_o  (sh_zero)
  );

  always_comb begin
    result_o     = a;
    f            = flags_in_i;
    write_back_o = 1'b0;
    case (op)
      CMD_ADD, CMD_INC: begin
        result_o     = add_r;
        f            = status_flags(add_r, sign);
        f[FL_AF]     = a[4] ^ b_eff[4] ^ add_r[4];
        f[FL_CF]     = (op == CMD_INC) ? flags_in_i[FL_CF] : carry_at(sum, wc);
        f[FL_OF]     = |((a ^ b_eff ^ sign) & (add_r ^ a) & sign);
        write_back_o = 1'b1;
      end
      CMD_SUB, CMD_SBB, CMD_CMP, CMD_DEC: begin
        result_o     = sub_r;
        f            = status_flags(sub_r, sign);
        f[FL_AF]     = a[4] ^ b_eff[4] ^ sub_r[4];
        f[FL_CF]     = (op == CMD_DEC) ? flags_in_i[FL_CF] : carry_at(diff, wc);
        f[FL_OF]     = |((a ^ b_eff) & (sub_r ^ a) & sign);
        write_back_o = (op != CMD_CMP);
      end
      CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
        if (op == CMD_OR) begin
          result_o = a | b;
        end else if (op == CMD_XOR) begin
          result_o = a ^ b;
        end else begin
          result_o = a & b;
        end
        f            = status_flags(result_o, sign);
        write_back_o = (op != CMD_TEST);
      end
      CMD_SHL, CMD_SHR, CMD_SAR: begin
        if (!sh_zero) begin
          result_o     = sh_r;
          f            = status_flags(sh_r, sign);
          f[FL_CF]     = sh_cf;
          if (op == CMD_SHR) begin
            f[FL_OF] = |(a & sign);
          end else if (op == CMD_SHL) begin
            f[FL_OF] = (|(a & sign)) ^ (|(a & (sign >> 1)));
          end
          write_back_o = 1'b1;
        end
      end
      default: begin
        result_o     = a;
        f            = flags_in_i;
        write_back_o = 1'b0;
      end
    endcase
  end

  assign flags_out_o = f;

endmodule

// ===== hw/rtl/x86_integer_alu_flags_unit.sv =====
// Top level of the x86 integer ALU with flags: input register, datapath, result register.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+------------------------------------------------
//   in      | in_valid_i  | in_stall_o   | cmd_i width_code_i operand_a_i operand_b_i flags_in_i
//   out     | out_valid_o | out_stall_i  | result_o flags_out_o write_back_o
//
// One item per cycle sustained while the output is not stalled; each item passes through
// the input register and then the result register, which sit around the adder/shifter,
// before its result is shown on the output.
// Reset clears both valid bits; payload registers are not reset.
// A stall on the output holds the result register and backs up into the input
// register; in_stall_o rises only when both registers hold an item.
module x86_integer_alu_flags_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [xalu_pkg::CmdW-1:0]   cmd_i,
  input  logic [xalu_pkg::WidthW-1:0] width_code_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_a_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_b_i,
  input  logic [xalu_pkg::FlagW-1:0]  flags_in_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [xalu_pkg::DataW-1:0]  result_o,
  output logic [xalu_pkg::FlagW-1:0]  flags_out_o,
  output logic                        write_back_o
);
  import xalu_pkg::*;

  logic              s1_valid_q, s1_valid_d;
  logic [CmdW-1:0]   s1_cmd_q;
  logic [WidthW-1:0] s1_wc_q;
  logic [DataW-1:0]  s1_a_q;
  logic [DataW-1:0]  s1_b_q;
  logic [FlagW-1:0]  s1_flags_q;

  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  result_q;
  logic [FlagW-1:0]  flags_q;
  logic              wb_q;

  logic [DataW-1:0]  result_d;
  logic [FlagW-1:0]  flags_d;
  logic              wb_d;

  logic              s2_ready;
  logic              s1_load;
  logic              s2_load;

  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign s1_load    = in_valid_i && !in_stall_o;
  assign s2_load    = s1_valid_q && s2_ready;

  assign s1_valid_d  = s1_load || (s1_valid_q && !s2_ready);
  assign out_valid_d = s2_load || (out_valid_q && out_stall_i);

  xalu_core u_core (
    .cmd_i        (s1_cmd_q),
    .width_code_i (s1_wc_q),
    .operand_a_i  (s1_a_q),
    .operand_b_i  (s1_b_q),
    .flags_in_i   (s1_flags_q),
    .result_o     (result_d),
    .flags_out_o  (flags_d),
    .write_back_o (wb_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_cmd_q   <= cmd_i;
      s1_wc_q    <= width_code_i;
      s1_a_q     <= operand_a_i;
      s1_b_q     <= operand_b_i;
      s1_flags_q <= flags_in_i;
    end
    if (s2_load) begin
      result_q <= result_d;
      flags_q  <= flags_d;
      wb_q     <= wb_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_o     = result_q;
  assign flags_out_o  = flags_q;
  assign write_back_o = wb_q;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without both stages full");

  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_load |=> out_valid_o)
    else $error("item left input register but no result shown");

  a_hold_under_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && $stable(s1_a_q))
    else $error("input register lost its item under stall");

  a_no_wb_compare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_cmd_q == CMD_CMP || s1_cmd_q == CMD_TEST) |-> !wb_d)
    else $error("compare or test flagged for write-back");
`endif

endmodule

// ===== tb/sv/alu_flags_checker.sv =====
// Checker for the x86 integer ALU: predicts result and flags per input transfer and compares outputs.
`timescale 1ns / 100ps

module alu_flags_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [xalu_pkg::CmdW-1:0]   cmd_i,
  input  logic [xalu_pkg::WidthW-1:0] width_code_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_a_i,
  input  logic [xalu_pkg::DataW-1:0]  operand_b_i,
  input  logic [xalu_pkg::FlagW-1:0]  flags_in_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [xalu_pkg::DataW-1:0]  result_i,
  input  logic [xalu_pkg::FlagW-1:0]  flags_out_i,
  input  logic                        write_back_i,
  output int unsigned                 mismatch_count_o,
  output int unsigned                 pending_o
);
  import xalu_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic [FlagW-1:0] flags;
    logic             write_back;
  } alu_outcome_t;

  alu_outcome_t expected_q[$];
  alu_outcome_t head;

  function automatic logic [FlagW-1:0] zero_sign_parity(input logic [DataW-1:0] r,
                                                        input logic [DataW-1:0] sign);
    logic [FlagW-1:0] f;
    f        = '0;
    f[FL_PF] = ~^r[7:0];
    f[FL_ZF] = (r == '0);
    f[FL_SF] = |(r & sign);
    return f;
  endfunction

  function automatic alu_outcome_t predict_outcome(input logic [CmdW-1:0]   op,
                                                   input logic [WidthW-1:0] wc,
                                                   input logic [DataW-1:0]  a_raw,
                                                   input logic [DataW-1:0]  b_raw,
                                                   input logic [FlagW-1:0]  f_in);
    int unsigned             w;
    logic [DataW-1:0]        mask, sign, a, b, r, ext;
    logic signed [DataW-1:0] sar;
    logic [FlagW-1:0]        f;
    logic [CntW-1:0]         cnt;
    logic                    wb, carry;
    alu_outcome_t            o;
    w     = 8 << wc;
    mask  = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    sign  = 64'd1 << (w - 1);
    a     = a_raw & mask;
    b     = b_raw & mask;
    r     = a;
    f     = f_in;
    wb    = 1'b0;
    carry = 1'b0;
    case (op)
      CMD_ADD, CMD_INC: begin
        if (op == CMD_INC) b = 64'd1;
        r        = (a + b) & mask;
        f        = zero_sign_parity(r, sign);
        f[FL_AF] = a[4] ^ b[4] ^ r[4];
        f[FL_CF] = (op == CMD_ADD) ? (r < a) : f_in[FL_CF];
        f[FL_OF] = |((a ^ b ^ sign) & (r ^ a) & sign);
        wb       = 1'b1;
      end
      CMD_SUB, CMD_SBB, CMD_CMP, CMD_DEC: begin
        if (op == CMD_DEC) b = 64'd1;
        r = (a - b) & mask;
        if (op == CMD_SBB && f_in[FL_CF]) r = (r - 64'd1) & mask;
        f        = zero_sign_parity(r, sign);
        f[FL_AF] = a[4] ^ b[4] ^ r[4];
        if (op == CMD_SBB) begin
          f[FL_CF] = (a < r) || (f_in[FL_CF] && b == mask);
        end else if (op == CMD_DEC) begin
          f[FL_CF] = f_in[FL_CF];
        end else begin
          f[FL_CF] = (a < b);
        end
        f[FL_OF] = |((a ^ b) & (r ^ a) & sign);
        wb       = (op != CMD_CMP);
      end
      CMD_AND, CMD_OR, CMD_XOR, CMD_TEST: begin
        if (op == CMD_OR) begin
          r = a | b;
        end else if (op == CMD_XOR) begin
          r = a ^ b;
        end else begin
          r = a & b;
        end
        f  = zero_sign_parity(r, sign);
        wb = (op != CMD_TEST);
      end
      CMD_SHL, CMD_SHR, CMD_SAR: begin
        cnt = (w == 64) ? b_raw[5:0] : {1'b0, b_raw[4:0]};
        if (cnt != '0) begin
          if (op == CMD_SHL) begin
            if (cnt <= w) carry = a[w - cnt];
            r = (a << cnt) & mask;
          end else if (op == CMD_SHR) begin
            carry = a[cnt - 1];
            r     = a >> cnt;
          end else begin
            ext   = (|(a & sign)) ? (a | ~mask) : a;
            carry = ext[cnt - 1];
            sar   = $signed(ext) >>> cnt;
            r     = sar & mask;
          end
          f        = zero_sign_parity(r, sign);
          f[FL_CF] = carry;
          if (op == CMD_SHR) f[FL_OF] = |(a & sign);
          if (op == CMD_SHL) f[FL_OF] = (|(a & sign)) ^ (|(a & (sign >> 1)));
          wb = 1'b1;
        end
      end
      default: ;
    endcase
    o.result     = r & mask;
    o.flags      = f;
    o.write_back = wb;
    return o;
  endfunction

  initial begin
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, result %h flags %h write_back %b",
                   $time, result_i, flags_out_i, write_back_i);
          mismatch_count_o++;
        end else begin
          head = expected_q.pop_front();
          if (result_i !== head.result) begin
            $display("%0t: result expected %h actual %h", $time, head.result, result_i);
            mismatch_count_o++;
          end
          if (flags_out_i !== head.flags) begin
            $display("%0t: flags_out expected %h actual %h", $time, head.flags, flags_out_i);
            mismatch_count_o++;
          end
          if (write_back_i !== head.write_back) begin
            $display("%0t: write_back expected %b actual %b",
                     $time, head.write_back, write_back_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(predict_outcome(cmd_i, width_code_i, operand_a_i,
                                             operand_b_i, flags_in_i));
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_x86_integer_alu_flags_unit.sv =====
// Testbench top for the x86 integer ALU: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_x86_integer_alu_flags_unit;
  import xalu_pkg::*;

  localparam logic [CmdW-1:0] CMD_RSVD_FIRST = 4'd13;
  localparam logic [CmdW-1:0] CMD_RSVD_LAST  = 4'd15;
  localparam int unsigned     NumRandom      = 750;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CmdW-1:0]   cmd_i;
  logic [WidthW-1:0] width_code_i;
  logic [DataW-1:0]  operand_a_i;
  logic [DataW-1:0]  operand_b_i;
  logic [FlagW-1:0]  flags_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [DataW-1:0]  result_o;
  logic [FlagW-1:0]  flags_out_o;
  logic              write_back_o;
  int unsigned       mismatches;
  int unsigned       pending_results;
  int unsigned       burst_left;

  x86_integer_alu_flags_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .width_code_i (width_code_i),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .flags_in_i   (flags_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result_o),
    .flags_out_o  (flags_out_o),
    .write_back_o (write_back_o)
  );

  alu_flags_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .cmd_i            (cmd_i),
    .width_code_i     (width_code_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .flags_in_i       (flags_in_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_i         (result_o),
    .flags_out_i      (flags_out_o),
    .write_back_i     (write_back_o),
    .mismatch_count_o (mismatches),
    .pending_o        (pending_results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // offer one transfer, hold it until accepted, then idle the sender for a random gap that may be zero
  task automatic offer_item(input logic [CmdW-1:0] op, input width_e wc,
                            input logic [DataW-1:0] a, input logic [DataW-1:0] b,
                            input logic [FlagW-1:0] fl);
    int unsigned gap;
    int unsigned roll;
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    width_code_i <= wc;
    operand_a_i  <= a;
    operand_b_i  <= b;
    flags_in_i   <= fl;
    do @(posedge clk_i); while (in_stall_o);
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      gap        = 0;
    end else if (roll < 55) begin
      gap = 0;
    end else if (roll < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = 64'd1 << ((8 << $urandom_range(0, 3)) - 1);
      3:       v = (64'd1 << ((8 << $urandom_range(0, 3)) - 1)) - 64'd1;
      4:       v = {$urandom, $urandom} | ((64'd1 << (8 << $urandom_range(0, 2))) - 64'd1);
      5:       v = $urandom_range(0, 255);
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic offer_random_item();
    logic [CmdW-1:0]  op;
    width_e           wc;
    logic [DataW-1:0] a, b;
    int unsigned      w;
    int unsigned      cnt;
    if ($urandom_range(0, 99) < 4) begin
      op = CmdW'($urandom_range(int'(CMD_RSVD_FIRST), int'(CMD_RSVD_LAST)));
    end else begin
      op = CmdW'($urandom_range(int'(CMD_ADD), int'(CMD_SAR)));
    end
    wc = width_e'($urandom_range(0, 3));
    w  = 8 << wc;
    a  = pick_operand();
    b  = pick_operand();
    if (op >= CMD_SHL && op <= CMD_SAR && $urandom_range(0, 99) < 40) begin
      case ($urandom_range(0, 6))
        0:       cnt = 0;
        1:       cnt = 1;
        2:       cnt = w - 1;
        3:       cnt = w;
        4:       cnt = w + 1;
        5:       cnt = 31;
        default: cnt = 63;
      endcase
      b = (b & ~64'h3F) | 64'(cnt & 32'h3F);
    end
    offer_item(op, wc, a, b, FlagW'($urandom_range(0, 63)));
  endtask

  initial begin
    int unsigned roll;
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (60) @(posedge clk_i);
    forever begin
      roll = $urandom_range(0, 999);
      if (roll < 5) begin
        out_stall_i <= 1'b1;
        hold        = $urandom_range(40, 90);
      end else if (roll < 30) begin
        out_stall_i <= 1'b0;
        hold        = $urandom_range(20, 60);
      end else if (roll < 600) begin
        out_stall_i <= 1'b0;
        hold        = 1;
      end else if (roll < 960) begin
        out_stall_i <= 1'b1;
        hold        = $urandom_range(1, 3);
      end else begin
        out_stall_i <= 1'b1;
        hold        = $urandom_range(5, 20);
      end
      repeat (hold) @(posedge clk_i);
    end
  end

  initial begin
    in_valid_i   = 1'b0;
    cmd_i        = CMD_ADD;
    width_code_i = WID_8;
    operand_a_i  = '0;
    operand_b_i  = '0;
    flags_in_i   = '0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(CMD_ADD,  WID_8,  64'h7F, 64'h01, 6'h00);
    offer_item(CMD_ADD,  WID_64, '1, 64'h1, 6'h3F);
    offer_item(CMD_ADD,  WID_8,  64'hFFFF_FFFF_FFFF_FF80, 64'hAAAA_AAAA_AAAA_AA80, 6'h00);
    offer_item(CMD_INC,  WID_16, 64'hFFFF, 64'h1234, 6'h01);
    offer_item(CMD_SUB,  WID_32, 64'h0, 64'h1, 6'h00);
    offer_item(CMD_SBB,  WID_8,  64'h10, 64'hFF, 6'h01);
    offer_item(CMD_SBB,  WID_64, 64'h0, 64'h0, 6'h01);
    offer_item(CMD_CMP,  WID_64, 64'h8000_0000_0000_0000, 64'h1, 6'h00);
    offer_item(CMD_DEC,  WID_8,  64'h80, 64'hFF, 6'h01);
    offer_item(CMD_AND,  WID_64, '1, 64'h8000_0000_0000_0000, 6'h3F);
    offer_item(CMD_OR,   WID_16, 64'h00F0, 64'h0F00, 6'h3F);
    offer_item(CMD_XOR,  WID_32, 64'h1234_5678, 64'h1234_5678, 6'h00);
    offer_item(CMD_TEST, WID_8,  64'hF0, 64'h0F, 6'h25);
    offer_item(CMD_SHL,  WID_32, 64'h8000_0001, 64'h20, 6'h2A);
    offer_item(CMD_SHL,  WID_8,  64'h01, 64'h08, 6'h00);
    offer_item(CMD_SHL,  WID_16, 64'hFFFF, 64'h1F, 6'h00);
    offer_item(CMD_SHL,  WID_64, 64'h4000_0000_0000_0001, 64'h3F, 6'h00);
    offer_item(CMD_SHR,  WID_64, 64'h8000_0000_0000_0000, 64'h1, 6'h00);
    offer_item(CMD_SHR,  WID_8,  64'hFF, 64'h14, 6'h00);
    offer_item(CMD_SAR,  WID_8,  64'h80, 64'h1F, 6'h00);
    offer_item(CMD_SAR,  WID_64, 64'h8000_0000_0000_0000, 64'h3F, 6'h00);
    offer_item(CMD_SAR,  WID_32, 64'h7000_0010, 64'h5, 6'h3F);
    offer_item(CMD_RSVD_FIRST, WID_16, 64'hDEAD_BEEF_CAFE_F00D, 64'h1, 6'h15);
    offer_item(CMD_RSVD_LAST,  WID_64, 64'hDEAD_BEEF_CAFE_F00D, 64'h2, 6'h2A);
    drain_results();

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) drain_results();
      offer_random_item();
    end
    drain_results();
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && pending_results == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
